// ===== hdl/sidta_pkg.sv =====
// package for the signed integer to decimal ascii converter
// holds state and unit opcode types, character constants and digit count helper
// no dependencies
`default_nettype none

package sidta_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DABBLE,
        OP_SHIFT
    } t_bcd_op;

    // decimal digits of the largest magnitude, 2**(width-1)
    function automatic int digits_for_width(input int width);
        return ((width - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sidta_bcd_unit.sv =====
// shared shift and add-3 unit of the converter
// holds the binary shift register and the bcd digit register
// depends on sidta_pkg
`default_nettype none

module sidta_bcd_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire sidta_pkg::t_bcd_op     i_op,
    input  wire logic [VALUE_WIDTH-1:0] i_mag,
    output logic      [3:0]             o_top
);
    import sidta_pkg::*;

    localparam int NUM_DIGITS = digits_for_width(VALUE_WIDTH);
    localparam int BCD_W      = NUM_DIGITS * 4;

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [VALUE_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       n_bcd;
    logic [BCD_W-1:0]       w_adj;

    // add 3 to every digit of five or more
    always_comb begin
        logic [3:0] d;
        d = 4'd0;
        w_adj = r_bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = r_bcd[i*4 +: 4];
            w_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        case (i_op)
            OP_LOAD: begin
                n_bin = i_mag;
                n_bcd = '0;
            end
            OP_DABBLE: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
            end
            OP_SHIFT: begin
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
            end
            default: begin
                n_bin = r_bin;
                n_bcd = r_bcd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top = r_bcd[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii_top.sv =====
// sequence: load the magnitude, shift-add-3 over every bit of it, then align by shifting out
// leading zero digits, then strobe the sign if the value is negative and the digits in order
// one value at a time, set by the single bcd unit doing one bit per cycle; busy stays high
// from the accepted start until the sequencer is back in idle after the last character
// synchronous active-low reset returns the sequencer to idle; characters are
// strobed for one cycle each and the receiver cannot stall
`default_nettype none

module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                               o_valid,
    output logic             [7:0]             o_character,
    output logic                               o_last
);
    import sidta_pkg::*;

    localparam int NUM_DIGITS = digits_for_width(VALUE_WIDTH);
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [LEFT_W-1:0]   r_left;
    logic [LEFT_W-1:0]   n_left;
    logic                r_neg;
    logic                n_neg;
    t_bcd_op             w_op;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [3:0]          w_top;

    assign w_val = i_value;
    assign w_mag = w_val[VALUE_WIDTH-1] ? (~w_val) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : w_val;

    sidta_bcd_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_bcd (
        .i_clk (i_clk),
        .i_op  (w_op),
        .i_mag (w_mag),
        .o_top (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_neg   <= n_neg;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_neg       = r_neg;
        w_op        = OP_HOLD;
        busy        = 1'b1;
        o_valid     = 1'b0;
        o_character = CHAR_ZERO + {4'd0, w_top};
        o_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    w_op    = OP_LOAD;
                    n_neg   = w_val[VALUE_WIDTH-1];
                    n_cnt   = CNT_W'(VALUE_WIDTH);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_op  = OP_DABBLE;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_top == 4'd0 && r_left > LEFT_W'(1)) begin
                    w_op   = OP_SHIFT;
                    n_left = r_left - LEFT_W'(1);
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                o_valid     = 1'b1;
                o_character = CHAR_MINUS;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_valid = 1'b1;
                o_last  = (r_left == LEFT_W'(1));
                w_op    = OP_SHIFT;
                n_left  = r_left - LEFT_W'(1);
                if (r_left == LEFT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !busy)
        else $error("not idle after last character");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == CHAR_MINUS |-> !o_last)
        else $error("sign emitted as last character");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == CHAR_MINUS) ||
                    (o_character >= CHAR_ZERO && o_character <= CHAR_ZERO + 8'd9))
        else $error("illegal character");

    a_minus_after_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == CHAR_MINUS |-> $past(r_state) == S_SKIP)
        else $error("sign not directly after digit alignment");

endmodule

`default_nettype wire

// ===== tb/sv/decimal_text_checker.sv =====
// checker for the signed integer to decimal ascii converter: predicts the text of
// every accepted value and compares each strobed character against it
// depends on sidta_pkg for the character constants
module decimal_text_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_valid,
    input  logic [7:0]             i_character,
    input  logic                   i_last,
    output int                     o_pending,
    output int                     o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import sidta_pkg::*;

    logic [7:0] text_chars[$];
    logic       text_last[$];
    logic [7:0] want_char;
    logic       want_last;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        o_errors++;
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic push_decimal_text(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [63:0]            rest;
        logic [7:0]             digits[20];
        int                     nd;
        int                     total;
        mag  = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
        rest = 64'(mag);
        nd   = 0;
        do begin
            digits[nd] = CHAR_ZERO + 8'(rest % 10);
            nd++;
            rest = rest / 10;
        end while (rest != 0);
        total = nd + (v[VALUE_WIDTH-1] ? 1 : 0);
        if (v[VALUE_WIDTH-1]) begin
            text_chars.push_back(CHAR_MINUS);
            text_last.push_back(total == 1);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            text_chars.push_back(digits[i]);
            text_last.push_back(i == 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1) begin
                if (text_chars.size() == 0) begin
                    report_mismatch("character with nothing pending", i_character, -1);
                end else begin
                    want_char = text_chars.pop_front();
                    want_last = text_last.pop_front();
                    if (i_character !== want_char) begin
                        report_mismatch("character", i_character, want_char);
                    end
                    if (i_last !== want_last) begin
                        report_mismatch("last flag", i_last, want_last);
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                push_decimal_text(i_value);
            end
        end
        o_pending = text_chars.size();
    end

endmodule

// ===== tb/sv/tb_signed_int_to_decimal_ascii_top.sv =====
// testbench top for signed_int_to_decimal_ascii_top: drives directed and random values
// with random gaps and a back-to-back burst, and gives the verdict from the checker's error count
// depends on the block, sidta_pkg and decimal_text_checker
module tb_signed_int_to_decimal_ascii_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH = 32;
    localparam int NUM_RANDOM  = 420;
    localparam int CYCLE_LIMIT = 200000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_valid;
    logic [7:0]             o_character;
    logic                   o_last;
    int                     pending;
    int                     errors;
    int                     cycle_count;

    logic [VALUE_WIDTH-1:0] directed_values[22] = '{
        32'd0, 32'd1, -32'sd1, 32'd5, 32'd9, 32'd10, -32'sd9, -32'sd10,
        32'd99, 32'd100, -32'sd999, 32'd1000, 32'd123456789, -32'sd987654321,
        32'd999999999, 32'd1000000000, -32'sd1000000000, 32'h7fffffff,
        -32'sd2147483647, 32'h80000000, 32'd1999999999, -32'sd2000000000
    };

    signed_int_to_decimal_ascii_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    decimal_text_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_value     (i_value),
        .i_valid     (o_valid),
        .i_character (o_character),
        .i_last      (o_last),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint decade(input int n);
        longint r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] random_value();
        longint                 lo;
        longint                 hi;
        longint                 mag;
        int                     n;
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom;
            end
            1: begin
                // uniform digit count, then uniform within that decade
                n   = $urandom_range(1, 10);
                lo  = decade(n - 1);
                hi  = (n == 10) ? 64'd2147483647 : decade(n) - 1;
                mag = lo + longint'($urandom) % (hi - lo + 1);
                v   = 32'(mag);
                if ($urandom_range(0, 1)) v = -v;
            end
            2: begin
                // around a power of ten
                n   = $urandom_range(0, 9);
                mag = decade(n) + $urandom_range(0, 2) - 1;
                v   = 32'(mag);
                if ($urandom_range(0, 1)) v = -v;
                if ($urandom_range(0, 7) == 0) begin
                    v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
                end
            end
            default: begin
                v = 32'($urandom_range(0, 40)) - 32'd20;
            end
        endcase
        return v;
    endfunction

    // entered at a falling edge with start low; the gap counts idle cycles of the block
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input int gap);
        while (busy !== 1'b0) begin
            @(negedge i_clk);
        end
        repeat (gap) begin
            @(negedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int gap;
        start   = 1'b0;
        i_value = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_values[k]) begin
            send_value(directed_values[k], $urandom_range(0, 4));
        end

        for (int k = 0; k < NUM_RANDOM; k++) begin
            if (k == 150) begin
                wait_drained();
            end
            // back to back burst in the middle
            gap = (k >= 250 && k < 310) ? 0 : $urandom_range(0, 4);
            send_value(random_value(), gap);
        end

        wait_drained();
        repeat (60) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
